// ===== src/msp_pkg.sv =====
// msp_pkg: shared types, code constants and morse tables for the symbol packer
// used by every module of morse_symbol_packer; no dependencies
package msp_pkg;

    localparam int LETTER_W       = 5;
    localparam int WORD_W         = 64;
    localparam int COUNT_W        = 16;
    localparam int CODE_W         = 2;
    localparam int CODES_PER_WORD = WORD_W / CODE_W;
    localparam int CODE_CNT_W     = $clog2(CODES_PER_WORD);
    localparam int MAX_CODES      = 5;
    localparam int LEN_W          = 3;
    localparam int PAT_W          = 4;

    localparam logic [LETTER_W-1:0] LETTER_COUNT = LETTER_W'(26);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

    localparam logic [CODE_W-1:0] CODE_DOT  = 2'b00;
    localparam logic [CODE_W-1:0] CODE_DASH = 2'b01;
    localparam logic [CODE_W-1:0] CODE_SEP  = 2'b10;
    localparam logic [CODE_W-1:0] CODE_END  = 2'b11;

    typedef struct packed {
        logic [WORD_W-1:0]  packed_word;
        logic [COUNT_W-1:0] word_count;
        logic               final_word;
    } result_t;

    // up to two results per letter, first one in slot zero
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } push_t;

    // number of morse symbols of a letter
    function automatic logic [LEN_W-1:0] sym_len(input logic [LETTER_W-1:0] letter);
        logic [LEN_W-1:0] len;
        case (letter)
            5'd0:    len = 3'd2;
            5'd1:    len = 3'd4;
            5'd2:    len = 3'd4;
            5'd3:    len = 3'd3;
            5'd4:    len = 3'd1;
            5'd5:    len = 3'd4;
            5'd6:    len = 3'd3;
            5'd7:    len = 3'd4;
            5'd8:    len = 3'd2;
            5'd9:    len = 3'd4;
            5'd10:   len = 3'd3;
            5'd11:   len = 3'd4;
            5'd12:   len = 3'd2;
            5'd13:   len = 3'd2;
            5'd14:   len = 3'd3;
            5'd15:   len = 3'd4;
            5'd16:   len = 3'd4;
            5'd17:   len = 3'd3;
            5'd18:   len = 3'd3;
            5'd19:   len = 3'd1;
            5'd20:   len = 3'd3;
            5'd21:   len = 3'd4;
            5'd22:   len = 3'd3;
            5'd23:   len = 3'd4;
            5'd24:   len = 3'd4;
            5'd25:   len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // symbol pattern, dash as 1, first symbol in the highest used bit
    function automatic logic [PAT_W-1:0] sym_bits(input logic [LETTER_W-1:0] letter);
        logic [PAT_W-1:0] pat;
        case (letter)
            5'd0:    pat = 4'h1;
            5'd1:    pat = 4'h8;
            5'd2:    pat = 4'hA;
            5'd3:    pat = 4'h4;
            5'd4:    pat = 4'h0;
            5'd5:    pat = 4'h2;
            5'd6:    pat = 4'h6;
            5'd7:    pat = 4'h0;
            5'd8:    pat = 4'h0;
            5'd9:    pat = 4'h7;
            5'd10:   pat = 4'h5;
            5'd11:   pat = 4'h4;
            5'd12:   pat = 4'h3;
            5'd13:   pat = 4'h2;
            5'd14:   pat = 4'h7;
            5'd15:   pat = 4'h6;
            5'd16:   pat = 4'hD;
            5'd17:   pat = 4'h2;
            5'd18:   pat = 4'h0;
            5'd19:   pat = 4'h1;
            5'd20:   pat = 4'h1;
            5'd21:   pat = 4'h1;
            5'd22:   pat = 4'h3;
            5'd23:   pat = 4'h9;
            5'd24:   pat = 4'hB;
            5'd25:   pat = 4'hC;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/msp_letter_if.sv =====
// msp_letter_if: valid/ready channel that carries one letter per transfer
// depends on msp_pkg
interface msp_letter_if;
    logic                           valid;
    logic                           ready;
    logic [msp_pkg::LETTER_W-1:0]   letter;
    logic                           last_letter;

    modport source (output valid, output letter, output last_letter, input ready);
    modport sink   (input valid, input letter, input last_letter, output ready);
endinterface

// ===== src/msp_word_if.sv =====
// msp_word_if: valid/ready channel that carries one packed word per transfer
// depends on msp_pkg
interface msp_word_if;
    logic                           valid;
    logic                           ready;
    logic [msp_pkg::WORD_W-1:0]     packed_word;
    logic [msp_pkg::COUNT_W-1:0]    word_count;
    logic                           final_word;

    modport source (output valid, output packed_word, output word_count, output final_word,
                    input ready);
    modport sink   (input valid, input packed_word, input word_count, input final_word,
                    output ready);
endinterface

// ===== src/msp_encoder.sv =====
// msp_encoder: letter input register, packing state and the single-pass
// code packer; depends on msp_pkg and msp_letter_if
module msp_encoder (
    input  logic              clk,
    input  logic              rst_n,
    msp_letter_if.sink        letters,
    input  logic              room,
    output msp_pkg::push_t    push
);

    localparam int CODES_W = msp_pkg::MAX_CODES * msp_pkg::CODE_W;
    localparam int EXT_W   = msp_pkg::WORD_W + CODES_W;
    localparam int SHL_W   = $clog2(msp_pkg::WORD_W) + 1;
    localparam int SHR_W   = $clog2(CODES_W + 1);
    localparam int TOT_W   = msp_pkg::CODE_CNT_W + 1;

    logic                                   item_valid_reg;
    logic [msp_pkg::LETTER_W-1:0]           letter_reg;
    logic                                   last_reg;
    logic [msp_pkg::WORD_W-1:0]             partial_reg;
    logic [msp_pkg::WORD_W-1:0]             partial_next;
    logic [msp_pkg::CODE_CNT_W-1:0]         codes_reg;
    logic [msp_pkg::CODE_CNT_W-1:0]         codes_next;
    logic [msp_pkg::COUNT_W-1:0]            emitted_reg;
    logic [msp_pkg::COUNT_W-1:0]            emitted_next;

    logic                                   advance;
    logic                                   letter_ok;
    logic [msp_pkg::LEN_W-1:0]              len;
    logic [msp_pkg::PAT_W-1:0]              pat;
    logic [CODES_W-1:0]                     codes;
    logic [msp_pkg::LEN_W-1:0]              num_codes;
    logic [EXT_W-1:0]                       ext;
    logic [EXT_W-1:0]                       ext_shl;
    logic [EXT_W-1:0]                       ext_shr;
    logic [SHL_W-1:0]                       fill_shift;
    logic [SHR_W-1:0]                       align_shift;
    logic [TOT_W-1:0]                       total;
    logic                                   overflow;
    logic [msp_pkg::CODE_CNT_W-1:0]         remain;
    logic [msp_pkg::WORD_W-1:0]             keep_mask;
    logic [msp_pkg::WORD_W-1:0]             after_push;
    logic [SHL_W-1:0]                       pad_shift;
    logic [msp_pkg::WORD_W-1:0]             full_word;
    logic [msp_pkg::WORD_W-1:0]             padded_word;
    logic [msp_pkg::COUNT_W-1:0]            count_one;
    logic [msp_pkg::COUNT_W-1:0]            count_two;

    function automatic logic [msp_pkg::COUNT_W-1:0] sat_inc(
        input logic [msp_pkg::COUNT_W-1:0] value
    );
        return (value == msp_pkg::COUNT_MAX) ? value : value + 1'b1;
    endfunction

    assign advance       = item_valid_reg & room;
    assign letters.ready = ~item_valid_reg | room;

    // letter codes, first code top-aligned, separator after the symbols unless it is the last letter
    always_comb
    begin
        logic [1:0] pos;
        letter_ok = (letter_reg < msp_pkg::LETTER_COUNT);
        len       = msp_pkg::sym_len(letter_reg);
        pat       = msp_pkg::sym_bits(letter_reg);
        codes     = '0;
        pos       = '0;
        for (int i = 0; i < msp_pkg::MAX_CODES; i++)
        begin
            pos = 2'(len - msp_pkg::LEN_W'(i) - 1'b1);
            if (letter_ok && (msp_pkg::LEN_W'(i) < len))
            begin
                codes[CODES_W-1-msp_pkg::CODE_W*i -: msp_pkg::CODE_W] =
                    pat[pos] ? msp_pkg::CODE_DASH : msp_pkg::CODE_DOT;
            end
            else if (letter_ok && !last_reg && (msp_pkg::LEN_W'(i) == len))
            begin
                codes[CODES_W-1-msp_pkg::CODE_W*i -: msp_pkg::CODE_W] = msp_pkg::CODE_SEP;
            end
        end
        num_codes = letter_ok ? len + {2'b00, ~last_reg} : '0;
    end

    // pack: a word fills at most once per letter
    always_comb
    begin
        ext         = {partial_reg, codes};
        fill_shift  = {SHL_W'(7'd32 - {2'b00, codes_reg})} << 1;
        ext_shl     = ext << fill_shift;
        full_word   = ext_shl[EXT_W-1 -: msp_pkg::WORD_W];
        align_shift = SHR_W'({3'd5 - num_codes, 1'b0});
        ext_shr     = ext >> align_shift;
        total       = {1'b0, codes_reg} + TOT_W'(num_codes);
        overflow    = total[TOT_W-1];
        remain      = total[TOT_W-2:0];
        keep_mask   = ~({msp_pkg::WORD_W{1'b1}} << {remain, 1'b0});
        after_push  = ext_shr[msp_pkg::WORD_W-1:0] & keep_mask;
        pad_shift   = {SHL_W'(7'd32 - {2'b00, remain})} << 1;
        padded_word = (after_push << pad_shift) | ~({msp_pkg::WORD_W{1'b1}} << pad_shift);
        count_one   = sat_inc(emitted_reg);
        count_two   = sat_inc(count_one);
    end

    always_comb
    begin
        push.first_valid         = advance & (overflow | last_reg);
        push.second_valid        = advance & overflow & last_reg;
        push.first.packed_word   = overflow ? full_word : padded_word;
        push.first.word_count    = count_one;
        push.first.final_word    = ~overflow;
        push.second.packed_word  = padded_word;
        push.second.word_count   = count_two;
        push.second.final_word   = 1'b1;

        partial_next = partial_reg;
        codes_next   = codes_reg;
        emitted_next = emitted_reg;
        if (advance)
        begin
            if (last_reg)
            begin
                partial_next = '0;
                codes_next   = '0;
                emitted_next = '0;
            end
            else
            begin
                partial_next = after_push;
                codes_next   = remain;
                emitted_next = overflow ? count_one : emitted_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            partial_reg    <= '0;
            codes_reg      <= '0;
            emitted_reg    <= '0;
        end
        else
        begin
            if (letters.ready)
            begin
                item_valid_reg <= letters.valid;
            end
            partial_reg <= partial_next;
            codes_reg   <= codes_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (letters.valid && letters.ready)
        begin
            letter_reg <= letters.letter;
            last_reg   <= letters.last_letter;
        end
    end

endmodule

// ===== src/msp_result_fifo.sv =====
// msp_result_fifo: three-entry ordered result queue, two writes and one read
// per cycle; depends on msp_pkg and msp_word_if
module msp_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  msp_pkg::push_t    push,
    output logic              room,
    msp_word_if.source        words
);

    localparam int DEPTH = 3;
    localparam int CNT_W = $clog2(DEPTH + 1);

    msp_pkg::result_t           entry_reg [DEPTH];
    msp_pkg::result_t           entry_next [DEPTH];
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       pop;
    logic [CNT_W-1:0]           base;

    // room: at least two entries free, so two more results fit
    assign room = (count_reg <= CNT_W'(1));
    assign pop  = words.valid & words.ready;

    assign words.valid       = (count_reg != '0);
    assign words.packed_word = entry_reg[0].packed_word;
    assign words.word_count  = entry_reg[0].word_count;
    assign words.final_word  = entry_reg[0].final_word;

    always_comb
    begin
        base = count_reg - CNT_W'(pop);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && (i < DEPTH - 1))
            begin
                entry_next[i] = entry_reg[i+1];
            end
            else
            begin
                entry_next[i] = entry_reg[i];
            end
            if (push.first_valid && (CNT_W'(i) == base))
            begin
                entry_next[i] = push.first;
            end
            if (push.second_valid && (CNT_W'(i) == base + 1'b1))
            begin
                entry_next[i] = push.second;
            end
        end
        count_next = base + CNT_W'(push.first_valid) + CNT_W'(push.second_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

endmodule

// ===== src/morse_symbol_packer.sv =====
// morse_symbol_packer: letters in, 2-bit morse codes packed 32 to a 64-bit word out
// depends on msp_pkg, msp_letter_if, msp_word_if, msp_encoder, msp_result_fifo
// path: a word passes the input register and then a queue entry register before it can leave
// throughput: one letter per cycle while the queue has room; a letter filling a word and
//   ending the string makes two words and, with a ready consumer, holds the next letter
// reset: asynchronous, clears the partial word, code count, word count and queue
module morse_symbol_packer (
    input  logic          clk,
    input  logic          rst_n,
    msp_letter_if.sink    letters,
    msp_word_if.source    words
);

    // handshake between the packer and the result queue
    logic               room;
    msp_pkg::push_t     push;

    // input register plus the single-pass packer; a letter leaves the input
    // register only when the queue can take both words it may produce
    msp_encoder u_encoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .letters (letters),
        .room    (room),
        .push    (push)
    );

    // output side: ordered queue, head entry drives the word channel directly
    // from registers, so a stalled consumer never blocks the next letter while
    // at most one word is waiting
    msp_result_fifo u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .words (words)
    );

endmodule
